FILE: sv/cre_pkg.sv
// Shared types, character constants and class helper for the range expander.
package cre_pkg;

  localparam logic [7:0] DASH_CHAR = 8'h2D;
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;
  localparam logic [7:0] LOWER_LO  = 8'h61;
  localparam logic [7:0] LOWER_HI  = 8'h7A;
  localparam logic [7:0] UPPER_LO  = 8'h41;
  localparam logic [7:0] UPPER_HI  = 8'h5A;

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_DIGIT = 2'd1;
  localparam logic [1:0] CLS_LOWER = 2'd2;
  localparam logic [1:0] CLS_UPPER = 2'd3;

  typedef struct packed {
    logic load;   // take the request on the input side
    logic step;   // move one character into the output register
  } cre_cmd_t;

  typedef struct packed {
    logic plan_empty;  // the request being offered emits nothing
    logic has_work;    // characters remain in the emitter
    logic last_step;   // the next character is the final one of its request
  } cre_status_t;

  function automatic logic [1:0] char_class(input logic [7:0] c);
    logic [1:0] r;
    r = CLS_NONE;
    if (c >= DIGIT_LO && c <= DIGIT_HI) r = CLS_DIGIT;
    else if (c >= LOWER_LO && c <= LOWER_HI) r = CLS_LOWER;
    else if (c >= UPPER_LO && c <= UPPER_HI) r = CLS_UPPER;
    return r;
  endfunction

endpackage

FILE: sv/character_range_expander_core.sv
// Top level of the character range expander.
//
// channel | dir | tdata          | tlast
// s_*     | in  | [7:0] in_char  | in_final
// m_*     | out | [7:0] out_char | out_last
//
// A request is taken while the block is idle; its characters then leave at
// one per cycle while the output is not stalled, through the output register,
// 0 to 26 per request (a full z range with a flush), from the single-character
// emitter. Reset is synchronous and empties the look-ahead. A stalled output
// holds the emitter; no request is taken until all are in the output register.
module character_range_expander_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tlast,   // in_final
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast    // out_last
);
  import cre_pkg::*;

  cre_cmd_t    cmd;
  cre_status_t status;

  cre_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  cre_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_char  (s_tdata),
    .in_final (s_tlast),
    .out_char (m_tdata),
    .out_last (m_tlast)
  );

endmodule

FILE: sv/cre_datapath.sv
// Look-ahead state, emission plan and output data register.
module cre_datapath (
  input  logic                clk,
  input  logic                rst,
  input  cre_pkg::cre_cmd_t   cmd,
  output cre_pkg::cre_status_t status,
  input  logic [7:0]          in_char,
  input  logic                in_final,
  output logic [7:0]          out_char,
  output logic                out_last
);
  import cre_pkg::*;

  logic [7:0] held_char;
  logic       held_valid;
  logic       dash_pending;

  // emitter: a run cur..stop, then up to two single characters
  logic       run_active;
  logic [7:0] cur;
  logic [7:0] stop;
  logic [7:0] q1;
  logic [7:0] q2;
  logic [1:0] nq;

  // plan for the offered request
  logic       p_run;
  logic [7:0] p_start;
  logic [7:0] p_stop;
  logic [7:0] p_q1;
  logic [7:0] p_q2;
  logic [1:0] p_nq;
  logic [7:0] nh;
  logic       nv;
  logic       nd;
  logic       is_range;

  assign is_range = (in_char > held_char) &&
                    (char_class(in_char) == char_class(held_char));

  always_comb begin
    p_run   = 1'b0;
    p_start = held_char;
    p_stop  = held_char;
    p_q1    = DASH_CHAR;
    p_q2    = in_char;
    p_nq    = 2'd0;
    nh      = in_char;
    nv      = 1'b1;
    nd      = 1'b0;
    priority if (!held_valid) begin
      nh = in_char;
    end else if (dash_pending) begin
      p_run = 1'b1;
      if (is_range) begin
        p_stop = in_char - 8'd1;
      end else begin
        p_q1 = DASH_CHAR;
        p_nq = 2'd1;
      end
    end else if (in_char == DASH_CHAR && char_class(held_char) != CLS_NONE) begin
      nh = held_char;
      nd = 1'b1;
    end else begin
      p_run = 1'b1;
    end
    // flush appends what would stay held
    if (in_final) begin
      if (p_nq == 2'd1) begin
        p_q2 = nh;
        p_nq = 2'd2;
      end else begin
        p_q1 = nh;
        p_q2 = DASH_CHAR;
        p_nq = nd ? 2'd2 : 2'd1;
      end
      nh = 8'd0;
      nv = 1'b0;
      nd = 1'b0;
    end
  end

  assign status.plan_empty = !p_run && (p_nq == 2'd0);
  assign status.has_work   = run_active || (nq != 2'd0);
  assign status.last_step  = run_active ? ((cur == stop) && (nq == 2'd0)) : (nq == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char    <= 8'd0;
      held_valid   <= 1'b0;
      dash_pending <= 1'b0;
      run_active   <= 1'b0;
      nq           <= 2'd0;
    end else if (cmd.load) begin
      held_char    <= nh;
      held_valid   <= nv;
      dash_pending <= nd;
      run_active   <= p_run;
      nq           <= p_nq;
    end else if (cmd.step) begin
      if (run_active) begin
        if (cur == stop) run_active <= 1'b0;
      end else begin
        nq <= nq - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur  <= p_start;
      stop <= p_stop;
      q1   <= p_q1;
      q2   <= p_q2;
    end else if (cmd.step) begin
      if (run_active) begin
        cur <= cur + 8'd1;
      end else begin
        q1 <= q2;
      end
      out_char <= run_active ? cur : q1;
      out_last <= status.last_step;
    end
  end

endmodule

FILE: sv/cre_controller.sv
// Request sequencing and output valid control.
module cre_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output cre_pkg::cre_cmd_t    cmd,
  input  cre_pkg::cre_status_t status
);
  import cre_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic m_tvalid_next;

  assign s_tready = (state == ST_IDLE);
  assign cmd.load = s_tvalid && (state == ST_IDLE);
  assign cmd.step = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.load && !status.plan_empty) state_next = ST_EMIT;
      ST_EMIT: if (cmd.step && status.last_step) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.step) m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
    else m_tvalid_next = m_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> status.has_work) else $error("emit state with empty emitter");

  a_load_to_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !status.plan_empty) |=> (state == ST_EMIT))
    else $error("nonempty request did not start emission");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.last_step) |=> !status.has_work)
    else $error("work left after last character");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for character_range_expander_core: directed and random text.
module tb_top;
  import cre_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  // Tracks the expansion of every accepted request and checks each result character.
  class expansion_scoreboard;
    out_char_t  expected_q[$];
    logic [7:0] held_char;
    bit         held_valid;
    bit         dash_pending;
    int         mismatches;

    function new();
      held_char    = 8'h00;
      held_valid   = 0;
      dash_pending = 0;
      mismatches   = 0;
    endfunction

    function logic [1:0] class_of(logic [7:0] c);
      if (c >= DIGIT_LO && c <= DIGIT_HI) return CLS_DIGIT;
      if (c >= LOWER_LO && c <= LOWER_HI) return CLS_LOWER;
      if (c >= UPPER_LO && c <= UPPER_HI) return CLS_UPPER;
      return CLS_NONE;
    endfunction

    function void push_char(logic [7:0] c);
      out_char_t e;
      e.ch   = c;
      e.last = 1'b0;
      expected_q.push_back(e);
    endfunction

    function void note_request(logic [7:0] x, logic fin);
      int          first;
      int unsigned c;
      first = expected_q.size();
      if (!held_valid) begin
        held_char    = x;
        held_valid   = 1;
        dash_pending = 0;
      end else if (dash_pending) begin
        if (x > held_char && class_of(x) == class_of(held_char)) begin
          for (c = held_char; c < x; c++) push_char(c[7:0]);
        end else begin
          push_char(held_char);
          push_char(DASH_CHAR);
        end
        held_char    = x;
        dash_pending = 0;
      end else if (x == DASH_CHAR && class_of(held_char) != CLS_NONE) begin
        dash_pending = 1;
      end else begin
        push_char(held_char);
        held_char = x;
      end
      if (fin) begin
        if (held_valid) begin
          push_char(held_char);
          if (dash_pending) push_char(DASH_CHAR);
        end
        held_char    = 8'h00;
        held_valid   = 0;
        dash_pending = 0;
      end
      if (expected_q.size() > first) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [7:0] ch, logic last);
      out_char_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %02h last %0b with nothing expected", $realtime, ch, last);
        return;
      end
      e = expected_q.pop_front();
      if (ch !== e.ch || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected %02h last %0b, got %02h last %0b",
                   $realtime, e.ch, e.last, ch, last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] in_char
  logic       s_tlast;   // in_final
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] out_char
  logic       m_tlast;   // out_last

  expansion_scoreboard sb = new();
  bit         tx_idle = 1;
  bit         rx_idle = 1;
  int         items_sent = 0;
  int         rx_stall;
  logic [7:0] text_q[$];

  character_range_expander_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_item(logic [7:0] c, logic fin);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    sb.note_request(c, fin);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic send_queue();
    int i;
    for (i = 0; i < text_q.size(); i++) send_item(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly range shorthand with random ends, mixed with stray bytes and dashes.
  task automatic make_text();
    int         n;
    int         kind;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] s;
    logic [7:0] e;
    text_q.delete();
    n = $urandom_range(1, 4);
    repeat (n) begin
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
        0: begin lo = DIGIT_LO; hi = DIGIT_HI; end
        1: begin lo = LOWER_LO; hi = LOWER_HI; end
        default: begin lo = UPPER_LO; hi = UPPER_HI; end
      endcase
      if (kind < 6) begin
        s = 8'($urandom_range(hi, lo));
        if ($urandom_range(0, 4) == 0) e = 8'($urandom_range(0, 255));
        else if (s == hi) e = s;
        else e = 8'($urandom_range(hi, s + 1));
        text_q.push_back(s);
        text_q.push_back(DASH_CHAR);
        text_q.push_back(e);
        // chained range: the end starts the next one
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(DASH_CHAR);
          text_q.push_back((e < hi && $urandom_range(0, 3) != 0) ?
                           8'($urandom_range(hi, e + 1)) : 8'($urandom_range(0, 255)));
        end
      end else if (kind == 6) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 7) begin
        text_q.push_back(8'($urandom_range(0, 255)));
        text_q.push_back(DASH_CHAR);
      end else if (kind == 8) begin
        text_q.push_back(8'($urandom_range(hi, lo)));
        text_q.push_back(8'($urandom_range(hi, lo)));
      end else begin
        text_q.push_back(DASH_CHAR);
        text_q.push_back(DASH_CHAR);
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_text("a-z");
    send_text("0-9");
    send_text("A-Z");
    send_text("a-c-e");
    send_text("z-a-5");
    send_text("q-");
    // zero byte, high byte, then a dash after a byte of no class
    text_q = '{8'h00, 8'hFF, 8'h23, DASH_CHAR, 8'h78};
    send_queue();
    s_tvalid <= 1'b0;

    // hold off until the directed part has fully drained
    wait_drained();

    while (items_sent < 160) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      make_text();
      send_queue();
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      rx_stall = rx_idle ? $urandom_range(0, 16) : 0;
      if (rx_stall > 0) begin
        m_tready <= 1'b0;
        repeat (rx_stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1 || rst);
      sb.check_result(m_tdata, m_tlast);
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
